// ===== design/npa_pkg.sv =====
package npa_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int NUM_NODES  = 8;
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int NODE_W     = $clog2(NUM_NODES);
	localparam int NCNT_W     = $clog2(NUM_NODES + 1);
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int FAIL_W     = 32;
	localparam int NODES_CFG_W = 4;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 4;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef logic [NCNT_W-1:0] ncnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE     = 2'd1,
		OP_REGISTER = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_NOMEM   = 3'd1,
		ST_HWIGN   = 3'd2,
		ST_DOUBLE  = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_NODES_IN_USE    = 2'd0,
		CFG_FALLBACK_ENABLE = 2'd1
	} cfg_addr_t;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	typedef struct packed {
		logic  valid;
		page_t page;
	} link_t;

	typedef struct packed {
		logic hw;
		logic free;
	} mark_t;

	typedef struct packed {
		logic  found;
		node_t src;
		page_t page;
		logic  home_valid;
		page_t home_page;
	} head_sel_t;

	typedef struct packed {
		logic  we;
		node_t node;
		logic  valid;
		page_t page;
	} head_upd_t;

endpackage

// ===== design/npa_req_if.sv =====
interface npa_req_if;
	logic                        valid;
	logic                        ready;
	logic [npa_pkg::OP_W-1:0]    opcode;
	logic [npa_pkg::PAGE_W-1:0]  page_index;
	logic [npa_pkg::NODE_W-1:0]  home_node;

	modport source (output valid, output opcode, output page_index, output home_node,
		input ready);
	modport sink (input valid, input opcode, input page_index, input home_node,
		output ready);
endinterface

// ===== design/npa_rsp_if.sv =====
interface npa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [npa_pkg::STATUS_W-1:0]  status;
	logic [npa_pkg::PAGE_W-1:0]    granted_page;
	logic [npa_pkg::NODE_W-1:0]    granted_node;
	logic [npa_pkg::FAIL_W-1:0]    failure_count;

	modport source (output valid, output status, output granted_page, output granted_node,
		output failure_count, input ready);
	modport sink (input valid, input status, input granted_page, input granted_node,
		input failure_count, output ready);
endinterface

// ===== design/npa_cfg_if.sv =====
interface npa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [npa_pkg::CFG_ADDR_W-1:0]  addr;
	logic [npa_pkg::CFG_DATA_W-1:0]  wdata;

	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ===== design/npa_ram.sv =====
module npa_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/npa_head_file.sv =====
module npa_head_file (
	input  logic                clk,
	input  logic                arst_n,
	input  npa_pkg::node_t      node,
	input  npa_pkg::ncnt_t      node_cnt,
	input  logic                fallback,
	input  npa_pkg::head_upd_t  upd,
	output npa_pkg::head_sel_t  sel
);
	import npa_pkg::*;

	logic  head_valid_q [NUM_NODES];
	page_t head_page_q  [NUM_NODES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_NODES; i++) begin
				head_valid_q[i] <= 1'b0;
				head_page_q[i]  <= '0;
			end
		end else if (upd.we) begin
			head_valid_q[upd.node] <= upd.valid;
			head_page_q[upd.node]  <= upd.page;
		end
	end

	// The home node wins; with fallback enabled, otherwise the first non-empty list after it, wrapping at node_cnt.
	always_comb begin
		ncnt_t k;
		k              = '0;
		sel.found      = head_valid_q[node];
		sel.src        = node;
		sel.page       = head_page_q[node];
		sel.home_valid = head_valid_q[node];
		sel.home_page  = head_page_q[node];
		if (!head_valid_q[node] && fallback) begin
			for (int i = 1; i < NUM_NODES; i++) begin
				k = ncnt_t'({1'b0, node}) + ncnt_t'(i);
				if (k >= node_cnt) begin
					k = k - node_cnt;
				end
				if (!sel.found && (ncnt_t'(i) < node_cnt) && head_valid_q[k[NODE_W-1:0]]) begin
					sel.found = 1'b1;
					sel.src   = k[NODE_W-1:0];
					sel.page  = head_page_q[k[NODE_W-1:0]];
				end
			end
		end
	end
endmodule

// ===== design/numa_page_allocator.sv =====
// A result enters the output register as its request leaves S_EXEC, which stalls while an
// earlier result is unread. The read-modify-write of the shared link and mark memories holds
// a new request back until the last leaves S_EXEC; a held result waits while the next enters.
// Reset is asynchronous and active low; it empties all node lists and clears the failure count.
// After reset a pass over all 4096 entries zeroes the mark memory before any request is taken.
// Configuration writes are accepted in every cycle.
module numa_page_allocator (
	input  logic clk,
	input  logic arst_n,
	npa_req_if.sink   req,
	npa_rsp_if.source rsp,
	npa_cfg_if.sink   cfg
);
	import npa_pkg::*;

	state_t                 state_q;
	page_t                  clr_cnt_q;
	logic [NODES_CFG_W-1:0] nodes_q;
	logic                   fallback_q;
	ncnt_t                  node_cnt;

	op_t   op_q;
	page_t page_q;
	node_t node_q;
	page_t addr_q;
	logic  node_ok_q;
	logic  page_ok_q;
	head_sel_t sel_q;

	head_sel_t sel;
	head_upd_t head_upd;
	logic      accept;
	logic      load_ok;
	logic      commit;
	page_t     rd_addr;

	link_t link_rd;
	logic  link_we;
	link_t link_wdata;
	mark_t mark_rd;
	logic  mark_we;
	page_t mark_waddr;
	mark_t mark_wdata;
	logic  mark_we_exec;
	mark_t mark_wdata_exec;

	status_t             status_d;
	page_t               gpage_d;
	node_t               gnode_d;
	logic                fail_inc;
	logic [FAIL_W-1:0]   fail_q;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	page_t             rsp_page_q;
	node_t             rsp_node_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q    <= NODES_CFG_W'(1);
			fallback_q <= 1'b1;
		end else if (cfg.valid) begin
			if (cfg.addr == CFG_NODES_IN_USE) begin
				nodes_q <= cfg.wdata[NODES_CFG_W-1:0];
			end else if (cfg.addr == CFG_FALLBACK_ENABLE) begin
				fallback_q <= cfg.wdata[0];
			end
		end
	end

	always_comb begin
		priority if (nodes_q == '0) begin
			node_cnt = ncnt_t'(1);
		end else if (nodes_q > NODES_CFG_W'(NUM_NODES)) begin
			node_cnt = ncnt_t'(NUM_NODES);
		end else begin
			node_cnt = ncnt_t'(nodes_q);
		end
	end

	npa_head_file u_heads (
		.clk      (clk),
		.arst_n   (arst_n),
		.node     (req.home_node),
		.node_cnt (node_cnt),
		.fallback (fallback_q),
		.upd      (head_upd),
		.sel      (sel)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rd_addr   = (op_t'(req.opcode) == OP_ALLOC) ? sel.page : req.page_index;
	assign load_ok   = !rsp_valid_q || rsp.ready;
	assign commit    = (state_q == S_EXEC) && load_ok;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(req.opcode);
			page_q    <= req.page_index;
			node_q    <= req.home_node;
			addr_q    <= rd_addr;
			sel_q     <= sel;
			node_ok_q <= (ncnt_t'({1'b0, req.home_node}) < node_cnt);
			page_ok_q <= ({1'b0, req.page_index} < (PAGE_W + 1)'(NUM_PAGES));
		end
	end

	npa_ram #(
		.DEPTH (NUM_PAGES),
		.WIDTH ($bits(link_t))
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (page_q),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	npa_ram #(
		.DEPTH (NUM_PAGES),
		.WIDTH ($bits(mark_t))
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (mark_rd)
	);

	always_comb begin
		status_d        = ST_INVALID;
		gpage_d         = '0;
		gnode_d         = '0;
		fail_inc        = 1'b0;
		mark_we_exec    = 1'b0;
		mark_wdata_exec = mark_rd;
		link_we         = 1'b0;
		link_wdata      = '{valid: sel_q.home_valid, page: sel_q.home_page};
		head_upd        = '{we: 1'b0, node: node_q, valid: 1'b1, page: page_q};
		unique case (op_q)
			OP_ALLOC: begin
				if (node_ok_q) begin
					if (sel_q.found) begin
						status_d             = ST_OK;
						gpage_d              = addr_q;
						gnode_d              = sel_q.src;
						mark_we_exec         = 1'b1;
						mark_wdata_exec.free = 1'b0;
						head_upd             = '{we: 1'b1, node: sel_q.src,
							valid: link_rd.valid, page: link_rd.page};
					end else begin
						status_d = ST_NOMEM;
						fail_inc = 1'b1;
					end
				end
			end
			OP_FREE: begin
				if (page_ok_q && node_ok_q) begin
					if (mark_rd.hw) begin
						status_d = ST_HWIGN;
					end else if (mark_rd.free) begin
						status_d = ST_DOUBLE;
					end else begin
						status_d             = ST_OK;
						mark_we_exec         = 1'b1;
						mark_wdata_exec.free = 1'b1;
						link_we              = 1'b1;
						head_upd.we          = 1'b1;
					end
				end
			end
			OP_REGISTER: begin
				if (page_ok_q && !mark_rd.free && !mark_rd.hw) begin
					status_d           = ST_OK;
					mark_we_exec       = 1'b1;
					mark_wdata_exec.hw = 1'b1;
				end
			end
			OP_QUERY: begin
				if (page_ok_q && mark_rd.hw) begin
					status_d = ST_OK;
					gpage_d  = page_q;
				end
			end
			default: begin
				status_d = ST_INVALID;
			end
		endcase
		link_we     = link_we && commit;
		head_upd.we = head_upd.we && commit;
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			mark_we    = 1'b1;
			mark_waddr = clr_cnt_q;
			mark_wdata = '0;
		end else begin
			mark_we    = mark_we_exec && commit;
			mark_waddr = addr_q;
			mark_wdata = mark_wdata_exec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + PAGE_W'(1);
					if (clr_cnt_q == PAGE_W'(NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (load_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
				if (fail_inc) begin
					fail_q <= fail_q + FAIL_W'(1);
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_status_q <= status_d;
			rsp_page_q   <= gpage_d;
			rsp_node_q   <= gnode_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.granted_page  = rsp_page_q;
	assign rsp.granted_node  = rsp_node_q;
	assign rsp.failure_count = fail_q;

	a_no_mark_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mark_we)
		else $error("mark memory written while idle");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result presented without an executed request");

	a_fail_only_nomem: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && (fail_q != $past(fail_q))) |-> (rsp_status_q == ST_NOMEM))
		else $error("failure count moved without a no-memory result");

	a_head_upd_exec: assert property (@(posedge clk) disable iff (!arst_n)
		head_upd.we |-> (state_q == S_EXEC) && !(link_we && (op_q == OP_ALLOC)))
		else $error("list head updated outside execution");
endmodule

// ===== tb/sv/numa_page_allocator_test.sv =====
module numa_page_allocator_test;
	import npa_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		status_t           status;
		page_t             page;
		node_t             node;
		logic [FAIL_W-1:0] fails;
	} alloc_result_t;

	// Mirrors the per-node free lists and marks and keeps the results still owed by the block.
	class alloc_scoreboard;
		logic [NODES_CFG_W-1:0] nodes_cfg;
		bit                     fallback;
		bit                     head_valid[NUM_NODES];
		bit [PAGE_W-1:0]        head_page[NUM_NODES];
		bit                     link_valid[NUM_PAGES];
		bit [PAGE_W-1:0]        link_page[NUM_PAGES];
		bit                     free_mark[NUM_PAGES];
		bit                     hw_mark[NUM_PAGES];
		logic [FAIL_W-1:0]      fail_count;
		alloc_result_t          owed_q[$];
		int                     errors;

		function new();
			nodes_cfg = 1;
			fallback = 1'b1;
			fail_count = '0;
			errors = 0;
		endfunction

		function int unsigned active_nodes();
			if (nodes_cfg == 0)
				return 1;
			if (nodes_cfg > NUM_NODES)
				return NUM_NODES;
			return nodes_cfg;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void set_register(cfg_addr_t a, logic [CFG_DATA_W-1:0] d);
			case (a)
				CFG_NODES_IN_USE: begin
					nodes_cfg = d[NODES_CFG_W-1:0];
				end
				CFG_FALLBACK_ENABLE: begin
					fallback = d[0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_request(op_t op, page_t pg, node_t nd);
			alloc_result_t   r;
			int unsigned     n;
			int unsigned     home;
			int unsigned     src;
			int unsigned     k;
			bit              found;
			bit [PAGE_W-1:0] p;
			n = active_nodes();
			home = nd;
			r.status = ST_INVALID;
			r.page = '0;
			r.node = '0;
			case (op)
				OP_ALLOC: begin
					if (home < n) begin
						src = home;
						found = head_valid[home];
						if (!found && fallback) begin
							k = (home + 1) % n;
							while (!found && k != home) begin
								if (head_valid[k]) begin
									src = k;
									found = 1'b1;
								end else begin
									k = (k + 1) % n;
								end
							end
						end
						if (found) begin
							p = head_page[src];
							head_valid[src] = link_valid[p];
							head_page[src] = link_page[p];
							free_mark[p] = 1'b0;
							r.status = ST_OK;
							r.page = p;
							r.node = node_t'(src);
						end else begin
							fail_count = fail_count + 1;
							r.status = ST_NOMEM;
						end
					end
				end
				OP_FREE: begin
					if (home >= n) begin
						r.status = ST_INVALID;
					end else if (hw_mark[pg]) begin
						r.status = ST_HWIGN;
					end else if (free_mark[pg]) begin
						r.status = ST_DOUBLE;
					end else begin
						free_mark[pg] = 1'b1;
						link_valid[pg] = head_valid[home];
						link_page[pg] = head_page[home];
						head_valid[home] = 1'b1;
						head_page[home] = pg;
						r.status = ST_OK;
					end
				end
				OP_REGISTER: begin
					if (!free_mark[pg] && !hw_mark[pg]) begin
						hw_mark[pg] = 1'b1;
						r.status = ST_OK;
					end
				end
				default: begin
					if (hw_mark[pg]) begin
						r.status = ST_OK;
						r.page = pg;
					end
				end
			endcase
			r.fails = fail_count;
			owed_q.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, page_t pg, node_t nd,
				logic [FAIL_W-1:0] fc);
			alloc_result_t e;
			if (owed_q.size() == 0) begin
				$error("result transaction with no request outstanding");
				errors++;
				return;
			end
			e = owed_q.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (pg !== e.page) begin
				$error("granted_page: expected %0d, got %0d", e.page, pg);
				errors++;
			end
			if (nd !== e.node) begin
				$error("granted_node: expected %0d, got %0d", e.node, nd);
				errors++;
			end
			if (fc !== e.fails) begin
				$error("failure_count: expected %0d, got %0d", e.fails, fc);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	bit   sender_idle;
	bit   rsp_stall_on;
	bit   long_hold_req;

	alloc_scoreboard sb;

	npa_req_if req_ch();
	npa_rsp_if rsp_ch();
	npa_cfg_if cfg_ch();

	numa_page_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_result(rsp_ch.status, rsp_ch.granted_page, rsp_ch.granted_node,
				rsp_ch.failure_count);
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
			sb.note_request(op_t'(req_ch.opcode), req_ch.page_index, req_ch.home_node);
		if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
			sb.set_register(cfg_addr_t'(cfg_ch.addr), cfg_ch.wdata);
	end

	initial begin
		int burst;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 19);
				rsp_ch.ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(op_t op, page_t pg, node_t nd);
		int gap;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.page_index <= pg;
		req_ch.home_node <= nd;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (sender_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_register(cfg_addr_t a, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= a;
		cfg_ch.wdata <= d;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] nodes, bit fb);
		drain_requests();
		repeat (2) @(negedge clk);
		write_register(CFG_NODES_IN_USE, nodes);
		write_register(CFG_FALLBACK_ENABLE, {3'b000, fb});
	endtask

	// Most pages come from a small window so that pushes, pops and marks keep meeting.
	task automatic run_phase(int count, bit hold_rsp, bit pause_mid);
		int unsigned n;
		int unsigned base;
		int          pick;
		op_t         op;
		page_t       pg;
		node_t       nd;
		base = $urandom_range(0, NUM_PAGES - 64);
		if (hold_rsp)
			long_hold_req = 1'b1;
		for (int i = 0; i < count; i++) begin
			n = sb.active_nodes();
			pick = $urandom_range(0, 99);
			op = (pick < 38) ? OP_ALLOC : (pick < 80) ? OP_FREE :
				(pick < 90) ? OP_REGISTER : OP_QUERY;
			pick = $urandom_range(0, 99);
			if (pick < 75)
				pg = page_t'(base + $urandom_range(0, 47));
			else if (pick < 92)
				pg = page_t'($urandom_range(0, NUM_PAGES - 1));
			else
				pg = pick[0] ? '1 : '0;
			if ($urandom_range(0, 9) != 0)
				nd = node_t'($urandom_range(0, n - 1));
			else
				nd = node_t'($urandom_range(0, NUM_NODES - 1));
			send_request(op, pg, nd);
			if (pause_mid && i == count / 2)
				drain_requests();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ALLOC;
		req_ch.page_index = '0;
		req_ch.home_node = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = CFG_NODES_IN_USE;
		cfg_ch.wdata = '0;
		sender_idle = 1'b1;
		rsp_stall_on = 1'b1;
		long_hold_req = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		configure(4'd8, 1'b1);
		send_request(OP_QUERY, 12'h000, 3'd0);
		send_request(OP_ALLOC, 12'h000, 3'd0);
		send_request(OP_FREE, 12'h000, 3'd0);
		send_request(OP_FREE, 12'h000, 3'd0);
		send_request(OP_FREE, 12'hFFF, 3'd7);
		send_request(OP_ALLOC, 12'h000, 3'd0);
		send_request(OP_ALLOC, 12'h000, 3'd0);
		send_request(OP_ALLOC, 12'h000, 3'd3);
		send_request(OP_REGISTER, 12'hFFF, 3'd0);
		send_request(OP_REGISTER, 12'hFFF, 3'd0);
		send_request(OP_QUERY, 12'hFFF, 3'd7);
		send_request(OP_FREE, 12'hFFF, 3'd7);
		send_request(OP_FREE, 12'h000, 3'd2);
		send_request(OP_REGISTER, 12'h000, 3'd0);
		send_request(OP_FREE, 12'hAAA, 3'd5);
		send_request(OP_FREE, 12'h555, 3'd5);
		send_request(OP_ALLOC, 12'hFFF, 3'd5);
		send_request(OP_ALLOC, 12'h000, 3'd5);
		send_request(OP_ALLOC, 12'h555, 3'd7);

		configure(4'd4, 1'b0);
		send_request(OP_FREE, 12'h00A, 3'd5);
		send_request(OP_ALLOC, 12'h000, 3'd7);
		send_request(OP_FREE, 12'h00A, 3'd3);
		send_request(OP_ALLOC, 12'h000, 3'd0);
		send_request(OP_ALLOC, 12'h000, 3'd3);

		configure(4'd8, 1'b1);
		run_phase(250, 1'b0, 1'b0);
		configure(4'd1, 1'b1);
		run_phase(150, 1'b0, 1'b0);
		configure(4'd8, 1'b0);
		run_phase(200, 1'b1, 1'b0);
		configure(4'd0, 1'b1);
		run_phase(120, 1'b0, 1'b0);
		configure(4'd15, 1'b1);
		run_phase(200, 1'b0, 1'b1);
		configure(4'd3, 1'b1);
		run_phase(200, 1'b0, 1'b0);
		configure(4'd6, 1'b0);
		run_phase(200, 1'b0, 1'b0);
		configure(4'd8, 1'b1);
		sender_idle = 1'b0;
		rsp_stall_on = 1'b0;
		run_phase(400, 1'b0, 1'b0);

		drain_requests();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
design/npa_pkg.sv
design/npa_req_if.sv
design/npa_rsp_if.sv
design/npa_cfg_if.sv
design/npa_ram.sv
design/npa_head_file.sv
design/numa_page_allocator.sv
tb/sv/numa_page_allocator_test.sv
